[rtl/mvl_pkg.sv]
package mvl_pkg;

    localparam int VOICES_DEFAULT       = 8;
    localparam int SINE_ENTRIES_DEFAULT = 256;
    localparam int PHASE_W              = 24;
    localparam int SAMPLE_W             = 16;
    localparam int PW_W                 = 17;
    localparam int WAVE_W               = 3;
    localparam int CFG_IDX_W            = 1;

    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_SYNC   = 2'd1;
    localparam logic [1:0] OP_RATE   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH = 1'd1;

    localparam logic [2:0] WAVE_TRI    = 3'd0;
    localparam logic [2:0] WAVE_SAW    = 3'd1;
    localparam logic [2:0] WAVE_RSAW   = 3'd2;
    localparam logic [2:0] WAVE_SINE   = 3'd3;
    localparam logic [2:0] WAVE_SQUARE = 3'd4;
    localparam logic [2:0] WAVE_PULSE  = 3'd5;
    localparam logic [2:0] WAVE_VTRI   = 3'd6;
    localparam logic [2:0] WAVE_SH     = 3'd7;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

    // truncating quotient by shift and subtract, for table building only
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q, rem;
        q = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], a[i]};
            if (rem >= b) begin
                rem = rem - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // quarter-wave sine, evaluated at elaboration by a truncating series
    function automatic logic [15:0] sine_entry(input int k, input int entries);
        logic [63:0] x, x2, term, sum, r;
        logic [63:0] n;
        x = udiv64(64'(HALF_PI_Q30) * 64'(k), 64'(entries));
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (n = 1; n <= 6; n++) begin
            term = udiv64((term * x2) >> 30, (2 * n) * (2 * n + 1));
            if (n[0]) sum = sum - term;
            else sum = sum + term;
        end
        r = (sum * 64'd32768 + (64'd1 << 29)) >> 30;
        return (r > 64'd32767) ? 16'd32767 : r[15:0];
    endfunction

endpackage

[rtl/mvl_ram.sv]
module mvl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

[rtl/mvl_divider.sv]
// bit-serial restoring divider: quotient of {num,16'b0} / den, 17 bits
module mvl_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [16:0] num,
    input  logic [16:0] den,
    output logic        done,
    output logic [16:0] quo
);
    logic [17:0] rem_reg, rem_next;
    logic [32:0] dvd_reg;
    logic [16:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [18:0] trial;

    always_comb begin
        rem_next = {rem_reg[16:0], dvd_reg[32]};
        trial = {1'b0, rem_next} - {2'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd33;
                rem_reg  <= '0;
                dvd_reg  <= {num, 16'b0};
                den_reg  <= den;
            end else if (busy_reg) begin
                dvd_reg <= {dvd_reg[31:0], ~trial[18]};
                rem_reg <= trial[18] ? rem_next : trial[17:0];
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // after 33 shifts the low bits of dvd_reg hold the quotient
    assign quo = dvd_reg[16:0];
endmodule

[rtl/multi_voice_lfo_unit.sv]
// channel | dir | tdata (low bit up)                            | tuser
// s_axis  | in  | op[1:0] voice[4:2] rate_increment[28:5] pad   | -
// m_axis  | out | sample[15:0] signed Q1.15                     | -
// cfg     | in  | cfg_we, cfg_index (0 waveform, 1 pulse_width) | -
// one request at a time: a read passes S_RD, the bit-serial phase add in S_ADD
// and S_SHAPE, and its result is written in S_OUT; the variable triangle adds
// S_DIV for the 33-step divider; the input is free again once the result is written.
// sync and set rate free the input after S_RD; an unused op or absent voice stays idle.
// reset is synchronous, active low; memories need no clearing pass since
// a per-voice valid bit marks entries written since reset.
// a result waits in the output register; the next request is taken meanwhile.
module multi_voice_lfo_unit #(
    parameter int VOICES       = mvl_pkg::VOICES_DEFAULT,
    parameter int SINE_ENTRIES = mvl_pkg::SINE_ENTRIES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // op, voice, rate_increment
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // sample
    input  logic        cfg_we,
    input  logic [mvl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [16:0] cfg_wdata
);
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SW = $clog2(SINE_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_ADD, S_SHAPE, S_DIV, S_OUT
    } state_t;

    state_t state_reg;
    logic [2:0]  wave_reg;
    logic [16:0] pw_reg;
    logic [15:0] lfsr_reg;
    logic [1:0]  op_reg;
    logic [VW-1:0] voice_reg;
    logic [23:0] inc_reg;
    logic [VOICES-1:0] acc_vld_reg, step_vld_reg, held_vld_reg;

    logic [23:0] acc_sh_reg, step_sh_reg;
    logic        carry_reg;
    logic [4:0]  bit_cnt_reg;
    logic [15:0] out_reg;
    logic        out_vld_reg;
    logic        div_start_reg;

    // voice memories
    logic acc_we, step_we, held_we;
    logic [23:0] acc_wd, step_wd, acc_rd, step_rd;
    logic [15:0] held_wd, held_rd;
    logic [VW-1:0] rd_addr;

    // while idle the memories look at the offered voice, so data is ready in S_RD
    assign rd_addr = (state_reg == S_IDLE) ? VW'(s_axis_tdata[4:2]) : voice_reg;

    mvl_ram #(.WIDTH(24), .DEPTH(1 << VW)) u_acc (
        .aclk(aclk), .we(acc_we), .waddr(voice_reg), .wdata(acc_wd),
        .raddr(rd_addr), .rdata(acc_rd));
    mvl_ram #(.WIDTH(24), .DEPTH(1 << VW)) u_step (
        .aclk(aclk), .we(step_we), .waddr(voice_reg), .wdata(step_wd),
        .raddr(rd_addr), .rdata(step_rd));
    mvl_ram #(.WIDTH(16), .DEPTH(1 << VW)) u_held (
        .aclk(aclk), .we(held_we), .waddr(voice_reg), .wdata(held_wd),
        .raddr(rd_addr), .rdata(held_rd));

    logic [15:0] sine_rom [SINE_ENTRIES + 1];
    for (genvar k = 0; k <= SINE_ENTRIES; k++) begin : g_sine
        assign sine_rom[k] = mvl_pkg::sine_entry(k, SINE_ENTRIES);
    end

    // sum bit
    logic sbit, cnext;
    assign sbit  = acc_sh_reg[0] ^ step_sh_reg[0] ^ carry_reg;
    assign cnext = (acc_sh_reg[0] & step_sh_reg[0]) |
                   (carry_reg & (acc_sh_reg[0] ^ step_sh_reg[0]));

    // shaping, phase in acc_sh_reg after the add
    logic [23:0] ph;
    logic [15:0] p;
    logic [16:0] w_clip, dnum, dden, quo;
    logic        rising;
    logic [16:0] idx;
    logic [15:0] mag;
    logic [15:0] shaped;
    logic        div_done;
    logic [15:0] lfsr_adv;

    assign ph = acc_sh_reg;
    assign p  = ph[23:8];
    assign w_clip = pw_reg[16] ? 17'h10000 : pw_reg;
    assign rising = {1'b0, p} < w_clip;
    assign dnum = rising ? {1'b0, p} : 17'h10000 - {1'b0, p};
    assign dden = rising ? w_clip : 17'h10000 - w_clip;
    assign lfsr_adv = {1'b0, lfsr_reg[15:1]} ^ (lfsr_reg[0] ? mvl_pkg::LFSR_TAPS : 16'h0);

    mvl_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg),
        .num(dnum), .den(dden), .done(div_done), .quo(quo));

    always_comb begin
        logic [16:0] t;
        logic [SW+21:0] prod;
        prod = {{SW{1'b0}}, ph[21:0]} * (SW+22)'(SINE_ENTRIES);
        idx = 17'(prod[SW+21:22]);
        if (ph[22]) idx = 17'(SINE_ENTRIES) - idx;
        mag = sine_rom[idx[SW:0]];
        t = 17'h0;
        shaped = 16'h0;
        case (wave_reg)
            mvl_pkg::WAVE_TRI: begin
                t = p[15] ? 17'h10000 - {1'b0, p} : {1'b0, p};
                shaped = t[15] ? 16'h7FFF : {t[14:0], 1'b0} ^ 16'h8000;
            end
            mvl_pkg::WAVE_SAW:  shaped = p ^ 16'h8000;
            mvl_pkg::WAVE_RSAW: shaped = (p == 16'h0) ? 16'h7FFF : 16'h8000 - p;
            mvl_pkg::WAVE_SINE: shaped = ph[23] ? 16'h0 - mag : mag;
            mvl_pkg::WAVE_SQUARE: shaped = ph[23] ? 16'h8000 : 16'h7FFF;
            mvl_pkg::WAVE_PULSE:
                shaped = ({1'b0, ph} < {pw_reg, 8'h0}) ? 16'h7FFF : 16'h8000;
            mvl_pkg::WAVE_VTRI: shaped = quo[16] ? 16'h7FFF : quo[15:0] ^ 16'h8000;
            default: shaped = held_vld_reg[voice_reg] ? held_rd : 16'h0;
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg;

    always_comb begin
        acc_we = 1'b0; step_we = 1'b0; held_we = 1'b0;
        acc_wd = acc_sh_reg; step_wd = inc_reg; held_wd = lfsr_adv;
        if (state_reg == S_RD) begin
            if (op_reg == mvl_pkg::OP_SYNC) begin
                acc_we = 1'b1; acc_wd = '0;
            end
            if (op_reg == mvl_pkg::OP_RATE) step_we = 1'b1;
        end
        if (state_reg == S_ADD && bit_cnt_reg == 5'd0) begin
            acc_we = 1'b1;
            acc_wd = {sbit, acc_sh_reg[23:1]};
            held_we = cnext && wave_reg == mvl_pkg::WAVE_SH;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            wave_reg <= '0;
            pw_reg <= 17'd32768;
            lfsr_reg <= mvl_pkg::LFSR_SEED;
            acc_vld_reg <= '0; step_vld_reg <= '0; held_vld_reg <= '0;
            out_vld_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            div_start_reg <= (state_reg == S_SHAPE) && (wave_reg == mvl_pkg::WAVE_VTRI);
            if (cfg_we) begin
                if (cfg_index == mvl_pkg::REG_WAVEFORM) wave_reg <= cfg_wdata[2:0];
                if (cfg_index == mvl_pkg::REG_PULSE_WIDTH) pw_reg <= cfg_wdata;
            end
            if (out_vld_reg && m_axis_tready) out_vld_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    op_reg <= s_axis_tdata[1:0];
                    voice_reg <= VW'(s_axis_tdata[4:2]);
                    inc_reg <= s_axis_tdata[28:5];
                    if ({29'b0, s_axis_tdata[4:2]} < 32'(VOICES) &&
                        s_axis_tdata[1:0] != mvl_pkg::OP_UNUSED)
                        state_reg <= S_RD;
                end
                S_RD: begin
                    if (op_reg == mvl_pkg::OP_SYNC) begin
                        acc_vld_reg[voice_reg] <= 1'b1;
                        state_reg <= S_IDLE;
                    end else if (op_reg == mvl_pkg::OP_RATE) begin
                        step_vld_reg[voice_reg] <= 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= S_ADD;
                        acc_sh_reg <= acc_vld_reg[voice_reg] ? acc_rd : '0;
                        step_sh_reg <= step_vld_reg[voice_reg] ? step_rd : '0;
                        carry_reg <= 1'b0;
                        bit_cnt_reg <= 5'd23;
                    end
                end
                S_ADD: begin
                    acc_sh_reg <= {sbit, acc_sh_reg[23:1]};
                    step_sh_reg <= {1'b0, step_sh_reg[23:1]};
                    carry_reg <= cnext;
                    bit_cnt_reg <= bit_cnt_reg - 5'd1;
                    if (bit_cnt_reg == 5'd0) begin
                        acc_vld_reg[voice_reg] <= 1'b1;
                        if (cnext && wave_reg == mvl_pkg::WAVE_SH) begin
                            lfsr_reg <= lfsr_adv;
                            held_vld_reg[voice_reg] <= 1'b1;
                        end
                        state_reg <= S_SHAPE;
                    end
                end
                S_SHAPE: begin
                    if (wave_reg == mvl_pkg::WAVE_VTRI) state_reg <= S_DIV;
                    else state_reg <= S_OUT;
                end
                S_DIV: if (div_done) state_reg <= S_OUT;
                S_OUT: if (!out_vld_reg) begin
                    out_reg <= shaped;
                    out_vld_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/mvl_checker.sv]
module mvl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    // a waiting result holds its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a request never gives a result in the very next cycle
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result too early");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a shown result carries known data
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !$isunknown(m_axis_tdata))
        else $error("unknown result data");
endmodule

bind multi_voice_lfo_unit mvl_checker u_chk (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata));

[tb/lfo_checker.sv]
`timescale 1ns / 1ps

module lfo_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [mvl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [16:0] cfg_wdata,
    output int          fail_count,
    output int          samples_pending
);
    localparam int NV = mvl_pkg::VOICES_DEFAULT;
    localparam int NS = mvl_pkg::SINE_ENTRIES_DEFAULT;

    logic [23:0] acc_m [NV];
    logic [23:0] step_m [NV];
    logic [15:0] hold_m [NV];
    logic [15:0] lfsr_m;
    logic [2:0]  wave_m;
    logic [16:0] width_m;
    logic [15:0] quarter_sine [NS+1];
    logic [15:0] sample_q [$];

    // own quarter-wave table, same truncating series
    initial begin
        logic [63:0] x, x2, term, sum, r;
        for (int k = 0; k <= NS; k++) begin
            x = (64'(mvl_pkg::HALF_PI_Q30) * 64'(k)) / 64'(NS);
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (int n = 1; n <= 6; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) sum = sum - term;
                else sum = sum + term;
            end
            r = (sum * 64'd32768 + (64'd1 << 29)) >> 30;
            quarter_sine[k] = (r > 64'd32767) ? 16'd32767 : r[15:0];
        end
    end

    function automatic int clip_top(int v);
        return v > 32767 ? 32767 : v;
    endfunction

    function automatic logic [15:0] wave_value(int vc, logic [23:0] ph);
        int p, t, w, idx, mag, res;
        p = int'(ph[23:8]);
        case (wave_m)
            mvl_pkg::WAVE_TRI: begin
                t = p < 32768 ? p : 65536 - p;
                res = clip_top(2 * t - 32768);
            end
            mvl_pkg::WAVE_SAW:  res = p - 32768;
            mvl_pkg::WAVE_RSAW: res = clip_top(32768 - p);
            mvl_pkg::WAVE_SINE: begin
                idx = int'((longint'(ph[21:0]) * NS) >> 22);
                if (ph[22]) idx = NS - idx;
                mag = int'(quarter_sine[idx]);
                res = ph[23] ? -mag : mag;
            end
            mvl_pkg::WAVE_SQUARE: res = ph < 24'h800000 ? 32767 : -32768;
            mvl_pkg::WAVE_PULSE:
                res = (longint'(ph) < (longint'(width_m) << 8)) ? 32767 : -32768;
            mvl_pkg::WAVE_VTRI: begin
                w = width_m > 65536 ? 65536 : int'(width_m);
                if (p < w) res = clip_top(int'((longint'(p) << 16) / w) - 32768);
                else res = clip_top(int'((longint'(65536 - p) << 16) / (65536 - w)) - 32768);
            end
            default: res = int'($signed(hold_m[vc]));
        endcase
        return res[15:0];
    endfunction

    always @(posedge aclk) begin
        logic [1:0] op;
        logic [2:0] vc;
        logic [24:0] sum;
        logic [15:0] exp_s;
        if (!aresetn) begin
            for (int i = 0; i < NV; i++) begin
                acc_m[i] <= '0; step_m[i] <= '0; hold_m[i] = '0;
            end
            lfsr_m <= mvl_pkg::LFSR_SEED;
            wave_m <= mvl_pkg::WAVE_TRI;
            width_m <= 17'd32768;
            sample_q.delete();
            fail_count <= 0;
            samples_pending <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == mvl_pkg::REG_WAVEFORM) wave_m <= cfg_wdata[2:0];
                else if (cfg_index == mvl_pkg::REG_PULSE_WIDTH) width_m <= cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                op = s_axis_tdata[1:0];
                vc = s_axis_tdata[4:2];
                if (op == mvl_pkg::OP_SYNC) acc_m[vc] <= '0;
                else if (op == mvl_pkg::OP_RATE) step_m[vc] <= s_axis_tdata[28:5];
                else if (op == mvl_pkg::OP_READ) begin
                    sum = {1'b0, acc_m[vc]} + {1'b0, step_m[vc]};
                    acc_m[vc] <= sum[23:0];
                    if (sum[24] && wave_m == mvl_pkg::WAVE_SH) begin
                        logic [15:0] nl;
                        nl = lfsr_m >> 1;
                        if (lfsr_m[0]) nl = nl ^ mvl_pkg::LFSR_TAPS;
                        lfsr_m <= nl;
                        hold_m[vc] = nl;
                    end
                    exp_s = wave_value(vc, sum[23:0]);
                    sample_q.push_back(exp_s);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (sample_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected sample: expected none got %0d",
                                 $signed(m_axis_tdata));
                    fail_count <= fail_count + 1;
                end else begin
                    exp_s = sample_q.pop_front();
                    if (exp_s !== m_axis_tdata) begin
                        if (fail_count < 10)
                            $display("sample mismatch: expected %0d got %0d",
                                     $signed(exp_s), $signed(m_axis_tdata));
                        fail_count <= fail_count + 1;
                    end
                end
            end
            samples_pending <= sample_q.size();
        end
    end
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        cfg_we;
    logic [mvl_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [16:0] cfg_wdata;
    int          fail_count;
    int          samples_pending;
    int          cycle_count;
    bit          hold_off;

    multi_voice_lfo_unit DUT (.*);

    lfo_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > 800000) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off
    initial begin
        int gap;
        m_axis_tready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) m_axis_tready = 0;
            else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
                if (gap > 0) begin
                    m_axis_tready = 0;
                    repeat (gap) @(negedge aclk);
                end
                m_axis_tready = 1;
                @(posedge aclk);
                while (!m_axis_tvalid) @(posedge aclk);
            end
        end
    end

    task automatic send_request(logic [1:0] op, logic [2:0] vc, logic [23:0] inc, bit idle);
        int gap;
        gap = idle ? $urandom_range(0, 16) : 0;
        repeat (gap) @(negedge aclk);
        s_axis_tdata  = {3'b0, inc, vc, op};
        s_axis_tvalid = 1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
        s_axis_tvalid = 0;
    endtask

    task automatic write_reg(logic [mvl_pkg::CFG_IDX_W-1:0] idx, logic [16:0] val);
        // drain before touching configuration
        while (samples_pending != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        cfg_we = 1; cfg_index = idx; cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 0;
    endtask

    function automatic logic [23:0] pick_rate();
        case ($urandom_range(0, 4))
            0: return 24'hFFFFFF;
            1: return 24'h0;
            2: return 24'($urandom_range(0, 24'h3FFFF));
            default: return 24'($urandom());
        endcase
    endfunction

    initial begin
        logic [16:0] widths [6];
        logic [1:0]  op;
        bit          idle;
        widths = '{17'd0, 17'd1, 17'd65535, 17'd65536, 17'h1FFFF, 17'd32768};
        aresetn = 0; s_axis_tvalid = 0; s_axis_tdata = '0;
        cfg_we = 0; cfg_index = mvl_pkg::REG_WAVEFORM; cfg_wdata = '0; hold_off = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: reset state reads, extreme rates, sync, unused op
        send_request(mvl_pkg::OP_READ, 3'd0, 24'd0, 0);
        send_request(mvl_pkg::OP_RATE, 3'd0, 24'hFFFFFF, 0);
        send_request(mvl_pkg::OP_RATE, 3'd7, 24'h400000, 0);
        send_request(mvl_pkg::OP_READ, 3'd0, 24'd0, 0);
        send_request(mvl_pkg::OP_READ, 3'd0, 24'd0, 0);
        for (int i = 0; i < 5; i++) send_request(mvl_pkg::OP_READ, 3'd7, 24'hFFFFFF, 0);
        send_request(mvl_pkg::OP_SYNC, 3'd7, 24'd0, 0);
        send_request(mvl_pkg::OP_READ, 3'd7, 24'd0, 0);
        send_request(mvl_pkg::OP_UNUSED, 3'd7, 24'hFFFFFF, 0);
        send_request(mvl_pkg::OP_READ, 3'd7, 24'd0, 0);

        // long receiver hold-off while the sender keeps offering reads
        fork
            begin
                hold_off = 1;
                repeat (400) @(negedge aclk);
                hold_off = 0;
            end
            for (int i = 0; i < 12; i++) send_request(mvl_pkg::OP_READ, 3'(i), 24'd0, 0);
        join

        for (int phase = 0; phase < 16; phase++) begin
            write_reg(mvl_pkg::REG_WAVEFORM, 17'(phase % 8));
            write_reg(mvl_pkg::REG_PULSE_WIDTH,
                      (phase < 6) ? widths[phase] : 17'($urandom_range(0, 17'h1FFFF)));
            for (int v = 0; v < 8; v++) send_request(mvl_pkg::OP_RATE, 3'(v), pick_rate(), 1);
            for (int i = 0; i < 85; i++) begin
                idle = ($urandom_range(0, 9) < 3) ? 0 : 1;
                case ($urandom_range(0, 19))
                    0: op = mvl_pkg::OP_SYNC;
                    1, 2: op = mvl_pkg::OP_RATE;
                    3: op = mvl_pkg::OP_UNUSED;
                    default: op = mvl_pkg::OP_READ;
                endcase
                send_request(op, 3'($urandom_range(0, 7)),
                             (op == mvl_pkg::OP_RATE) ? pick_rate() : 24'($urandom()), idle);
            end
        end

        while (samples_pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (fail_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
